/* design/tgc_pkg.sv */
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared constants, types and helpers of the touch gesture classifier.
// ----------------------------------------------------------------------------
package tgc_pkg;

  localparam int unsigned MAX_SIDE   = 1024;
  localparam int unsigned RAW_LOW    = 200;
  localparam int unsigned RAW_HIGH   = 3800;
  localparam int unsigned RAW_SPAN   = RAW_HIGH - RAW_LOW;

  localparam int unsigned COORD_W    = 10;
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned RAW_W      = 12;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned MUL_W      = 23;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned RECIP_SH   = 34;
  localparam int unsigned Q_W        = 12;
  localparam logic [MUL_W-1:0] RECIP =
    MUL_W'(((64'd1 << RECIP_SH) + 64'(RAW_SPAN) - 64'd1) / 64'(RAW_SPAN));

  localparam logic [KIND_W-1:0] G_NONE  = 3'd0;
  localparam logic [KIND_W-1:0] G_LONG  = 3'd1;
  localparam logic [KIND_W-1:0] G_TAP   = 3'd2;
  localparam logic [KIND_W-1:0] G_RIGHT = 3'd3;
  localparam logic [KIND_W-1:0] G_LEFT  = 3'd4;
  localparam logic [KIND_W-1:0] G_DOWN  = 3'd5;
  localparam logic [KIND_W-1:0] G_UP    = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_EN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_MS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_RAD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SWIPE    = 3'd5;

  typedef struct packed {
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_op_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (s > SIZE_W'(MAX_SIDE)) begin
      r = SIZE_W'(MAX_SIDE);
    end
    return r;
  endfunction

  function automatic logic [RAW_W-1:0] raw_offset(input logic [RAW_W-1:0] raw);
    logic [RAW_W-1:0] r;
    r = '0;
    if (raw > RAW_W'(RAW_LOW)) begin
      r = raw - RAW_W'(RAW_LOW);
    end
    return r;
  endfunction

endpackage

/* design/tgc_mul.sv */
// ----------------------------------------------------------------------------
// tgc_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module tgc_mul
  import tgc_pkg::*;
(
  input  logic              clk_i,
  input  mul_op_t           op_i,
  output logic [PROD_W-1:0] prod_o
);

  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(op_i.a) * PROD_W'(op_i.b);
  end

  assign prod_o = prod_q;

endmodule

/* design/touch_gesture_classifier_unit.sv */
// ----------------------------------------------------------------------------
// touch_gesture_classifier_unit
// Maps touch-panel samples to screen points and classifies each press
// on release as long press, tap, swipe or none.
// ----------------------------------------------------------------------------
// usage: one sample per slave transaction (tuser = pressed, tdata = raw_x,
// raw_y, time_ms). a release after a press gives one master transaction
// (tuser = gesture kind, tdata = start, end point and hold time); all other
// samples give nothing. registers are written through cfg_we_i/cfg_addr_i/
// cfg_wdata_i while the block is idle.
// all arithmetic runs through one shared 23x23 multiplier under a small
// sequencer. a pressed sample takes two products per axis (scale by screen
// size, then divide by 3600 through a reciprocal), a release takes dx^2,
// dy^2, radius^2 and classify, and an idle release starts no work.
// s_axis_tready is high only while the sequencer is idle.
// the result sits in an output register, so a new sample is accepted while
// it waits; a release that finds the register still full waits in the
// classify step until the receiver takes the earlier result.
// reset restores the config defaults, clears the press state and empties the output.
// ----------------------------------------------------------------------------
module touch_gesture_classifier_unit
  import tgc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [55:0]           s_axis_tdata,  // raw_x, raw_y, time_ms
  input  logic                  s_axis_tuser,  // pressed
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [71:0]           m_axis_tdata,  // start_x, start_y, end_x, end_y, hold_ms
  output logic [KIND_W-1:0]     m_axis_tuser,  // gesture_kind
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MX1  = 4'd1;
  localparam logic [3:0] ST_MX2  = 4'd2;
  localparam logic [3:0] ST_MY1  = 4'd3;
  localparam logic [3:0] ST_MY2  = 4'd4;
  localparam logic [3:0] ST_MCOM = 4'd5;
  localparam logic [3:0] ST_SQX  = 4'd6;
  localparam logic [3:0] ST_SQY  = 4'd7;
  localparam logic [3:0] ST_SQR  = 4'd8;
  localparam logic [3:0] ST_CLS  = 4'd9;

  logic [3:0] state_q, state_d;

  logic                en_q;
  logic [SIZE_W-1:0]   width_q, height_q;
  logic [15:0]         long_ms_q;
  logic [COORD_W-1:0]  tap_rad_q, swipe_q;

  logic                down_q;
  logic [COORD_W-1:0]  org_x_q, org_y_q, rec_x_q, rec_y_q;
  logic [TIME_W-1:0]   org_t_q;

  logic [RAW_W-1:0]    rx_q, ry_q;
  logic [TIME_W-1:0]   now_q;
  logic [COORD_W-1:0]  map_x_q;
  logic [TIME_W-1:0]   hold_q;
  logic [20:0]         sum_q;

  logic                out_valid_q;
  logic [KIND_W-1:0]   kind_q;
  logic [71:0]         out_data_q;

  mul_op_t             op;
  logic [PROD_W-1:0]   prod;

  logic                in_fire, touched, out_free;
  logic [SIZE_W-1:0]   w_eff, h_eff, size_sel;
  logic [Q_W-1:0]      q;
  logic [COORD_W-1:0]  q_clamp;
  logic [COORD_W:0]    dx, dy;
  logic [COORD_W-1:0]  ax, ay;
  logic [20:0]         rr;
  logic [KIND_W-1:0]   kind;

  tgc_mul u_mul (
    .clk_i  (clk_i),
    .op_i   (op),
    .prod_o (prod)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign touched       = s_axis_tuser && en_q;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign w_eff    = eff_size(width_q);
  assign h_eff    = eff_size(height_q);
  // x quotient is clamped in ST_MY1, y quotient in ST_MCOM
  assign size_sel = (state_q == ST_MCOM) ? h_eff : w_eff;
  assign q        = prod[RECIP_SH +: Q_W];
  assign q_clamp  = (q >= Q_W'(size_sel)) ? COORD_W'(size_sel - SIZE_W'(1)) : q[COORD_W-1:0];

  assign dx = {1'b0, rec_x_q} - {1'b0, org_x_q};
  assign dy = {1'b0, rec_y_q} - {1'b0, org_y_q};
  assign ax = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
  assign ay = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
  assign rr = prod[20:0];

  always_comb begin
    op.a = '0;
    op.b = '0;
    unique case (state_q)
      ST_MX1: begin
        op.a = MUL_W'(raw_offset(rx_q));
        op.b = MUL_W'(w_eff);
      end
      ST_MY1: begin
        op.a = MUL_W'(raw_offset(ry_q));
        op.b = MUL_W'(h_eff);
      end
      ST_MX2, ST_MY2: begin
        op.a = prod[MUL_W-1:0];
        op.b = RECIP;
      end
      ST_SQX: begin
        op.a = MUL_W'(ax);
        op.b = MUL_W'(ax);
      end
      ST_SQY: begin
        op.a = MUL_W'(ay);
        op.b = MUL_W'(ay);
      end
      ST_SQR, ST_CLS: begin
        op.a = MUL_W'(tap_rad_q);
        op.b = MUL_W'(tap_rad_q);
      end
      default: begin
        op.a = '0;
        op.b = '0;
      end
    endcase
  end

  always_comb begin
    kind = G_NONE;
    priority if (hold_q > TIME_W'(long_ms_q)) begin
      kind = G_LONG;
    end else if (sum_q < rr) begin
      kind = G_TAP;
    end else if (ax > ay && ax > swipe_q) begin
      kind = dx[COORD_W] ? G_LEFT : G_RIGHT;
    end else if (ay > ax && ay > swipe_q) begin
      kind = dy[COORD_W] ? G_UP : G_DOWN;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (touched) begin
            state_d = ST_MX1;
          end else if (down_q) begin
            state_d = ST_SQX;
          end
        end
      end
      ST_MX1:  state_d = ST_MX2;
      ST_MX2:  state_d = ST_MY1;
      ST_MY1:  state_d = ST_MY2;
      ST_MY2:  state_d = ST_MCOM;
      ST_MCOM: state_d = ST_IDLE;
      ST_SQX:  state_d = ST_SQY;
      ST_SQY:  state_d = ST_SQR;
      ST_SQR:  state_d = ST_CLS;
      ST_CLS: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      en_q        <= 1'b0;
      width_q     <= SIZE_W'(480);
      height_q    <= SIZE_W'(320);
      long_ms_q   <= 16'd3000;
      tap_rad_q   <= COORD_W'(20);
      swipe_q     <= COORD_W'(50);
      down_q      <= 1'b0;
      org_x_q     <= '0;
      org_y_q     <= '0;
      org_t_q     <= '0;
      rec_x_q     <= '0;
      rec_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_TOUCH_EN: en_q      <= cfg_wdata_i[0];
          CFG_WIDTH:    width_q   <= cfg_wdata_i[SIZE_W-1:0];
          CFG_HEIGHT:   height_q  <= cfg_wdata_i[SIZE_W-1:0];
          CFG_LONG_MS:  long_ms_q <= cfg_wdata_i;
          CFG_TAP_RAD:  tap_rad_q <= cfg_wdata_i[COORD_W-1:0];
          CFG_SWIPE:    swipe_q   <= cfg_wdata_i[COORD_W-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_MCOM) begin
        if (!down_q) begin
          org_x_q <= map_x_q;
          org_y_q <= q_clamp;
          org_t_q <= now_q;
        end
        down_q  <= 1'b1;
        rec_x_q <= map_x_q;
        rec_y_q <= q_clamp;
      end
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_CLS && out_free) begin
        out_valid_q <= 1'b1;
        down_q      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rx_q  <= s_axis_tdata[11:0];
      ry_q  <= s_axis_tdata[23:12];
      now_q <= s_axis_tdata[55:24];
    end
    if (state_q == ST_MY1) begin
      map_x_q <= q_clamp;
    end
    if (state_q == ST_SQX) begin
      hold_q <= now_q - org_t_q;
    end
    if (state_q == ST_SQY) begin
      sum_q <= 21'(prod[19:0]);
    end
    if (state_q == ST_SQR) begin
      sum_q <= sum_q + 21'(prod[19:0]);
    end
    if (state_q == ST_CLS && out_free) begin
      kind_q     <= kind;
      out_data_q <= {hold_q, rec_y_q, rec_x_q, org_y_q, org_x_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tdata  = out_data_q;

  a_touch_starts_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && touched |=> state_q == ST_MX1)
    else $error("pressed sample did not start mapping");

  a_release_clears_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLS && out_free |=> !down_q && out_valid_q)
    else $error("release did not load a result");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= G_UP)
    else $error("gesture kind out of range");

  a_idle_release_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !touched && !down_q |=> state_q == ST_IDLE)
    else $error("release without press started work");

endmodule

/* tb/touch_gesture_classifier_unit_tb.sv */
// ----------------------------------------------------------------------------
// touch_gesture_classifier_unit_tb
// Self-checking bench for the touch gesture classifier. Samples go in over
// the slave stream, and a behavioral copy of the mapping, press tracking and
// classification predicts every gesture. Each master transaction is checked
// field by field against the oldest predicted gesture. Directed presses cover
// taps, swipes, long presses, clamping, time wrap and disable mid-press.
// Register extremes, back pressure and random press sequences follow, under
// several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module touch_gesture_classifier_unit_tb;
  import tgc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
    logic [TIME_W-1:0]  hold;
  } gesture_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [55:0]           s_axis_tdata;   // raw_x, raw_y, time_ms
  logic                  s_axis_tuser;   // pressed
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [71:0]           m_axis_tdata;   // start_x, start_y, end_x, end_y, hold_ms
  logic [KIND_W-1:0]     m_axis_tuser;   // gesture_kind
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // predicted register and press state
  logic               touch_en;
  logic [SIZE_W-1:0]  width_reg;
  logic [SIZE_W-1:0]  height_reg;
  logic [15:0]        long_ms_reg;
  logic [9:0]         tap_reg;
  logic [9:0]         swipe_reg;
  logic               held;
  logic [COORD_W-1:0] org_x;
  logic [COORD_W-1:0] org_y;
  logic [TIME_W-1:0]  org_t;
  logic [COORD_W-1:0] last_x;
  logic [COORD_W-1:0] last_y;

  gesture_t pending_gestures[$];
  int       n_errors = 0;
  int       n_sent = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  int       hold_left = 0;

  touch_gesture_classifier_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [COORD_W-1:0] scale_axis(input logic [RAW_W-1:0] raw,
                                                    input logic [SIZE_W-1:0] size_reg);
    longint size;
    longint v;
    size = size_reg;
    if (size < 1) size = 1;
    if (size > longint'(MAX_SIDE)) size = longint'(MAX_SIDE);
    v = (longint'(raw) - longint'(RAW_LOW)) * size / longint'(RAW_SPAN);
    if (v < 0) v = 0;
    if (v > size - 1) v = size - 1;
    return v[COORD_W-1:0];
  endfunction

  task automatic predict_touch(input logic pressed, input logic [RAW_W-1:0] rx,
                               input logic [RAW_W-1:0] ry, input logic [TIME_W-1:0] t);
    gesture_t g;
    longint   dx;
    longint   dy;
    longint   ax;
    longint   ay;
    longint   r;
    if (pressed && touch_en) begin
      last_x = scale_axis(rx, width_reg);
      last_y = scale_axis(ry, height_reg);
      if (!held) begin
        held  = 1'b1;
        org_x = last_x;
        org_y = last_y;
        org_t = t;
      end
    end else if (held) begin
      held = 1'b0;
      g.hold = t - org_t;
      dx = longint'(last_x) - longint'(org_x);
      dy = longint'(last_y) - longint'(org_y);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      r  = tap_reg;
      if (g.hold > TIME_W'(long_ms_reg))
        g.kind = G_LONG;
      else if (dx * dx + dy * dy < r * r)
        g.kind = G_TAP;
      else if (ax > ay && ax > longint'(swipe_reg))
        g.kind = dx > 0 ? G_RIGHT : G_LEFT;
      else if (ay > ax && ay > longint'(swipe_reg))
        g.kind = dy > 0 ? G_DOWN : G_UP;
      else
        g.kind = G_NONE;
      g.sx = org_x;
      g.sy = org_y;
      g.ex = last_x;
      g.ey = last_y;
      pending_gestures.push_back(g);
    end
  endtask

  // called and returning at a falling edge; tvalid stays high for the caller
  task automatic send_sample(input logic pressed, input logic [RAW_W-1:0] rx,
                             input logic [RAW_W-1:0] ry, input logic [TIME_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = pressed;
    s_axis_tdata  = {t, ry, rx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_touch(pressed, rx, ry, t);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    s_axis_tvalid = 1'b0;
    while (pending_gestures.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_TOUCH_EN: touch_en    = value[0];
      CFG_WIDTH:    width_reg   = value[SIZE_W-1:0];
      CFG_HEIGHT:   height_reg  = value[SIZE_W-1:0];
      CFG_LONG_MS:  long_ms_reg = value;
      CFG_TAP_RAD:  tap_reg     = value[9:0];
      CFG_SWIPE:    swipe_reg   = value[9:0];
      default: ;
    endcase
  endtask

  function automatic logic [RAW_W-1:0] nudge_raw(input logic [RAW_W-1:0] raw,
                                                 input int spread);
    int v;
    v = int'(raw) + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[RAW_W-1:0];
  endfunction

  // press, a few moves, release; one in ten items is a raw random sample
  task automatic gesture_run(input int n_items);
    int               target;
    int               spread;
    int               moves;
    logic [RAW_W-1:0] bx;
    logic [RAW_W-1:0] by;
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] hold;
    target = n_sent + n_items;
    while (n_sent < target) begin
      if ($urandom_range(9) == 0) begin
        send_sample(1'($urandom_range(1)), RAW_W'($urandom), RAW_W'($urandom), $urandom);
      end else begin
        case ($urandom_range(2))
          0: spread = 40;
          1: spread = 600;
          default: spread = 4095;
        endcase
        bx    = RAW_W'($urandom);
        by    = RAW_W'($urandom);
        t0    = $urandom;
        moves = $urandom_range(3);
        send_sample(1'b1, bx, by, t0);
        for (int i = 0; i < moves; i++)
          send_sample(1'b1, nudge_raw(bx, spread), nudge_raw(by, spread), t0 + i + 1);
        if ($urandom_range(4) == 0)
          hold = $urandom;
        else
          hold = $urandom_range(0, 2 * int'(long_ms_reg) + 64);
        send_sample(1'b0, RAW_W'($urandom), RAW_W'($urandom), t0 + hold);
      end
    end
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    // disabled panel and idle release give nothing
    send_sample(1'b1, 12'd2000, 12'd2000, 32'd100);
    send_sample(1'b0, 12'd2000, 12'd2000, 32'd110);
    write_reg(CFG_TOUCH_EN, 16'd1);
    // tap at the low clamp
    send_sample(1'b1, 12'd0, 12'd0, 32'd10);
    send_sample(1'b0, 12'd0, 12'd0, 32'd20);
    // high clamp, then swipe left
    send_sample(1'b1, 12'd4095, 12'd4095, 32'd30);
    send_sample(1'b1, 12'd200, 12'd200, 32'd40);
    send_sample(1'b0, 12'd0, 12'd0, 32'd50);
    // swipe right, down, up
    send_sample(1'b1, 12'd1000, 12'd2000, 32'd60);
    send_sample(1'b1, 12'd3000, 12'd2000, 32'd70);
    send_sample(1'b0, 12'd0, 12'd0, 32'd80);
    send_sample(1'b1, 12'd2000, 12'd1000, 32'd90);
    send_sample(1'b1, 12'd2000, 12'd3000, 32'd95);
    send_sample(1'b0, 12'd0, 12'd0, 32'd99);
    send_sample(1'b1, 12'd2000, 12'd3000, 32'd100);
    send_sample(1'b1, 12'd2000, 12'd1000, 32'd105);
    send_sample(1'b0, 12'd0, 12'd0, 32'd110);
    // long press, then a hold exactly at the limit
    send_sample(1'b1, 12'd2000, 12'd2000, 32'd1000);
    send_sample(1'b0, 12'd0, 12'd0, 32'd4001);
    send_sample(1'b1, 12'd2000, 12'd2000, 32'd5000);
    send_sample(1'b1, 12'd3000, 12'd2000, 32'd6000);
    send_sample(1'b0, 12'd0, 12'd0, 32'd8000);
    // hold across the timestamp wrap
    send_sample(1'b1, 12'd2000, 12'd2000, 32'hFFFF_FF00);
    send_sample(1'b0, 12'd0, 12'd0, 32'h0000_0010);
    // moved too far for a tap, too little for a swipe
    send_sample(1'b1, 12'd2000, 12'd2000, 32'd200);
    send_sample(1'b1, 12'd2225, 12'd2000, 32'd210);
    send_sample(1'b0, 12'd0, 12'd0, 32'd220);
    // disabled mid-press: next sample is a release
    send_sample(1'b1, 12'd1000, 12'd1000, 32'd300);
    write_reg(CFG_TOUCH_EN, 16'd0);
    send_sample(1'b1, 12'd3000, 12'd3000, 32'd310);
    write_reg(CFG_TOUCH_EN, 16'd1);
    // equal axes on a square screen
    write_reg(CFG_WIDTH, 16'd1024);
    write_reg(CFG_HEIGHT, 16'd1024);
    send_sample(1'b1, 12'd1000, 12'd1000, 32'd400);
    send_sample(1'b1, 12'd3000, 12'd3000, 32'd410);
    send_sample(1'b0, 12'd0, 12'd0, 32'd420);
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_WIDTH, 16'd0);
    write_reg(CFG_HEIGHT, 16'd2047);
    write_reg(CFG_LONG_MS, 16'd0);
    write_reg(CFG_TAP_RAD, 16'd0);
    write_reg(CFG_SWIPE, 16'd0);
    gesture_run(60);
    write_reg(CFG_WIDTH, 16'd1024);
    write_reg(CFG_HEIGHT, 16'd1);
    write_reg(CFG_LONG_MS, 16'd65535);
    write_reg(CFG_TAP_RAD, 16'd1023);
    write_reg(CFG_SWIPE, 16'd1023);
    gesture_run(60);
    write_reg(CFG_WIDTH, 16'd1025);
    write_reg(CFG_HEIGHT, 16'd1024);
    write_reg(CFG_LONG_MS, 16'd16);
    write_reg(CFG_TAP_RAD, 16'd5);
    write_reg(CFG_SWIPE, 16'd3);
    gesture_run(60);
  endtask

  task automatic test_backpressure();
    write_reg(CFG_WIDTH, 16'd480);
    write_reg(CFG_HEIGHT, 16'd320);
    write_reg(CFG_LONG_MS, 16'd3000);
    write_reg(CFG_TAP_RAD, 16'd20);
    write_reg(CFG_SWIPE, 16'd50);
    send_idle_pct = 0;
    stall_pct     = 0;
    @(posedge clk_i);
    hold_left = 400;
    @(negedge clk_i);
    gesture_run(40);
  endtask

  task automatic test_random_idling();
    int sender_mix[4]   = '{0, 84, 0, 6};
    int receiver_mix[4] = '{0, 0, 84, 6};
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_WIDTH, 16'($urandom_range(16, 1024)));
      write_reg(CFG_HEIGHT, 16'($urandom_range(16, 1024)));
      write_reg(CFG_LONG_MS, 16'($urandom_range(0, 4000)));
      write_reg(CFG_TAP_RAD, 16'($urandom_range(0, 120)));
      write_reg(CFG_SWIPE, 16'($urandom_range(0, 300)));
      send_idle_pct = sender_mix[p];
      stall_pct     = receiver_mix[p];
      gesture_run(200);
    end
  endtask

  // receiver: long hold-off when requested, else random stalls
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    gesture_t want;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (pending_gestures.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected transaction, expected none, actual kind %0d tdata %h",
                 $time, m_axis_tuser, m_axis_tdata);
      end else begin
        want = pending_gestures.pop_front();
        check_field("gesture_kind", 32'(want.kind), 32'(m_axis_tuser));
        check_field("start_x", 32'(want.sx), 32'(m_axis_tdata[9:0]));
        check_field("start_y", 32'(want.sy), 32'(m_axis_tdata[19:10]));
        check_field("end_x", 32'(want.ex), 32'(m_axis_tdata[29:20]));
        check_field("end_y", 32'(want.ey), 32'(m_axis_tdata[39:30]));
        check_field("hold_ms", want.hold, m_axis_tdata[71:40]);
      end
    end
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = CFG_TOUCH_EN;
    cfg_wdata_i   = '0;
    touch_en      = 1'b0;
    width_reg     = SIZE_W'(480);
    height_reg    = SIZE_W'(320);
    long_ms_reg   = 16'd3000;
    tap_reg       = 10'd20;
    swipe_reg     = 10'd50;
    held          = 1'b0;
    org_x         = '0;
    org_y         = '0;
    org_t         = '0;
    last_x        = '0;
    last_y        = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random_idling();

    s_axis_tvalid = 1'b0;
    while (pending_gestures.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
